[src/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;      // apply the accepted operation
        logic read;      // fetch front and back entries
        logic load_out;  // move the result into the output registers
    } dp_cmd_t;

endpackage

[src/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: accept a transaction, read back the ends, hand over the result.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output deq_pkg::dp_cmd_t cmd
);

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = deq_pkg::ST_READ;
                end
            end
            deq_pkg::ST_READ:
            begin
                state_next = deq_pkg::ST_DONE;
            end
            deq_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = deq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.exec     = 1'b0;
        cmd.read     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.exec = in_valid;
            end
            deq_pkg::ST_READ:
            begin
                cmd.read = 1'b1;
            end
            deq_pkg::ST_DONE:
            begin
                // wait until the output slot is free
                cmd.load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_exec_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> state_reg == deq_pkg::ST_READ)
        else $error("accepted transaction did not start a read");

    a_read_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == deq_pkg::ST_READ |=> state_reg == deq_pkg::ST_DONE)
        else $error("read not followed by result stage");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == deq_pkg::ST_DONE)
        else $error("result presented without a finished transaction");
`endif

endmodule

[src/deq_datapath.sv]
// ----------------------------------------------------------------------------
// deq_datapath
// Ring store, head/count pointers and output registers of the queue.
// ----------------------------------------------------------------------------
module deq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  deq_pkg::dp_cmd_t                  cmd,
    input  logic [deq_pkg::OP_W-1:0]          operation,
    input  logic signed [deq_pkg::DATA_W-1:0] value,
    output logic signed [deq_pkg::DATA_W-1:0] front_value,
    output logic signed [deq_pkg::DATA_W-1:0] back_value,
    output logic [$clog2(DEPTH+1)-1:0]        count,
    output logic                              is_empty,
    output logic                              rejected
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic signed [deq_pkg::DATA_W-1:0] ring_mem [DEPTH];

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic signed [deq_pkg::DATA_W-1:0] rd_front_reg;
    logic signed [deq_pkg::DATA_W-1:0] rd_back_reg;
    logic signed [deq_pkg::DATA_W-1:0] front_value_reg;
    logic signed [deq_pkg::DATA_W-1:0] back_value_reg;
    logic [CW-1:0]                     out_count_reg;
    logic                              is_empty_reg;
    logic                              rejected_reg;
    logic                              rejected_next;
    logic                              out_rejected_reg;

    logic          full;
    logic          empty;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_wr_addr;
    logic [AW-1:0] back_rd_addr;
    logic [CW-1:0] back_off;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    // head + offset folded back into the ring; the sum stays below 2*DEPTH
    function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = (s >= DEPTH_S) ? s - DEPTH_S : s;
        return r[AW-1:0];
    endfunction

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign back_off = empty ? '0 : count_reg - 1'b1;

    assign tail_wr_addr = ring_wrap(SW'(head_reg) + SW'(count_reg));
    assign back_rd_addr = ring_wrap(SW'(head_reg) + SW'(back_off));

    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        rejected_next = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = tail_wr_addr;
        case (deq_pkg::op_t'(operation))
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    head_next  = head_dec;
                    wr_addr    = head_dec;
                    wr_en      = cmd.exec;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    wr_en      = cmd.exec;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                if (empty)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rejected_reg <= rejected_next;
        end
    end

    // single write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= value;
        end
        if (cmd.read)
        begin
            rd_front_reg <= ring_mem[head_reg];
            rd_back_reg  <= ring_mem[back_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            front_value_reg  <= empty ? '0 : rd_front_reg;
            back_value_reg   <= empty ? '0 : rd_back_reg;
            out_count_reg    <= count_reg;
            is_empty_reg     <= empty;
            out_rejected_reg <= rejected_reg;
        end
    end

    assign front_value = front_value_reg;
    assign back_value  = back_value_reg;
    assign count       = out_count_reg;
    assign is_empty    = is_empty_reg;
    assign rejected    = out_rejected_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && wr_en |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("push did not advance fill count");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(count_reg) && $stable(head_reg))
        else $error("pointers moved without a transaction");
`endif

endmodule

[src/double_ended_queue_unit.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit values in a ring store.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | operation, value
//  output  | out_valid / out_ready| front_value, back_value, count, is_empty,
//          |                      | rejected
//
//  Each transaction applies its operation on acceptance, then does the
//  registered read of front and back from the single-write ring memory,
//  then loads the output register. in_ready is high only between
//  transactions. A waiting result does not stop the next transaction from
//  being accepted; it stalls only the hand-over of the following result.
//  Reset clears head and count; store contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [deq_pkg::OP_W-1:0]          operation,
    input  logic signed [deq_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [deq_pkg::DATA_W-1:0] front_value,
    output logic signed [deq_pkg::DATA_W-1:0] back_value,
    output logic [$clog2(DEPTH+1)-1:0]        count,
    output logic                              is_empty,
    output logic                              rejected
);

    deq_pkg::dp_cmd_t cmd;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (operation),
        .value       (value),
        .front_value (front_value),
        .back_value  (back_value),
        .count       (count),
        .is_empty    (is_empty),
        .rejected    (rejected)
    );

endmodule

[test/deque_checker.sv]
// ----------------------------------------------------------------------------
// deque_checker
// Watches both channels of the double-ended queue unit. It keeps its own
// ring store, predicts the front/back/count view for every accepted
// operation, and compares each returned transaction field by field.
// ----------------------------------------------------------------------------
module deque_checker #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [deq_pkg::OP_W-1:0]          operation,
    input  logic signed [deq_pkg::DATA_W-1:0] value,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [deq_pkg::DATA_W-1:0] front_value,
    input  logic signed [deq_pkg::DATA_W-1:0] back_value,
    input  logic [$clog2(DEPTH+1)-1:0]        count,
    input  logic                              is_empty,
    input  logic                              rejected,
    output int                                error_count,
    output int                                pending,
    output int                                results_checked,
    output int                                refused_seen,
    output int                                full_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [deq_pkg::DATA_W-1:0] front;
        logic signed [deq_pkg::DATA_W-1:0] back;
        logic [CW-1:0]                     count;
        logic                              empty;
        logic                              rejected;
    } deq_view_t;

    logic signed [deq_pkg::DATA_W-1:0] slots [DEPTH];
    int        head;
    int        fill;
    deq_view_t pending_views [$];
    int        errs;
    int        checked;
    int        refused;
    int        fulls;

    // Apply one operation to the local deque and return the view after it.
    function automatic deq_view_t advance_deque(deq_pkg::op_t op,
                                                logic signed [deq_pkg::DATA_W-1:0] val);
        deq_view_t v;
        v = '0;
        case (op)
            deq_pkg::OP_PUSH_FRONT:
                if (fill == DEPTH) v.rejected = 1'b1;
                else
                begin
                    head = (head + DEPTH - 1) % DEPTH;
                    slots[head] = val;
                    fill++;
                end
            deq_pkg::OP_PUSH_BACK:
                if (fill == DEPTH) v.rejected = 1'b1;
                else
                begin
                    slots[(head + fill) % DEPTH] = val;
                    fill++;
                end
            deq_pkg::OP_POP_FRONT:
                if (fill == 0) v.rejected = 1'b1;
                else
                begin
                    head = (head + 1) % DEPTH;
                    fill--;
                end
            default:
                if (fill == 0) v.rejected = 1'b1;
                else fill--;
        endcase
        // empty queue reads zero on both ends
        if (fill != 0)
        begin
            v.front = slots[head];
            v.back  = slots[(head + fill - 1) % DEPTH];
        end
        v.count = CW'(fill);
        v.empty = (fill == 0);
        return v;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deq_view_t want;
        if (!rst_n)
        begin
            head = 0;
            fill = 0;
            pending_views.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_views.size() == 0)
                begin
                    $error("result transaction with no operation outstanding");
                    errs++;
                end
                else
                begin
                    want = pending_views[0];
                    pending_views.delete(0);
                    check_field("front_value", longint'(want.front), longint'(front_value));
                    check_field("back_value", longint'(want.back), longint'(back_value));
                    check_field("count", longint'(want.count), longint'(count));
                    check_field("is_empty", longint'(want.empty), longint'(is_empty));
                    check_field("rejected", longint'(want.rejected), longint'(rejected));
                    checked++;
                    if (want.rejected) refused++;
                    if (want.count == CW'(DEPTH)) fulls++;
                end
            end
            if (in_valid && in_ready)
                pending_views.insert(pending_views.size(),
                                     advance_deque(deq_pkg::op_t'(operation), value));
        end
        error_count     <= errs;
        pending         <= pending_views.size();
        results_checked <= checked;
        refused_seen    <= refused;
        full_seen       <= fulls;
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the double-ended queue unit: a directed pass over empty and
// full corners and extreme values, then random operation mixes, balanced or
// biased toward filling or draining, with random idling on both channels, a
// long receiver hold-off and a sender pause. Checking is done by deque_checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH           = 16;
    localparam int CW              = $clog2(DEPTH + 1);
    localparam int RANDOM_OPS      = 1000;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int SETTLE_CYCLES   = 16;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    logic [deq_pkg::OP_W-1:0]          operation;
    logic signed [deq_pkg::DATA_W-1:0] value;
    logic                              out_valid;
    logic                              out_ready;
    logic signed [deq_pkg::DATA_W-1:0] front_value;
    logic signed [deq_pkg::DATA_W-1:0] back_value;
    logic [CW-1:0]                     count;
    logic                              is_empty;
    logic                              rejected;

    int error_count;
    int pending;
    int results_checked;
    int refused_seen;
    int full_seen;

    bit steady;      // no idling on either side while set
    int ops_sent;

    double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .front_value(front_value),
        .back_value (back_value),
        .count      (count),
        .is_empty   (is_empty),
        .rejected   (rejected)
    );

    deque_checker #(.DEPTH(DEPTH)) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .front_value    (front_value),
        .back_value     (back_value),
        .count          (count),
        .is_empty       (is_empty),
        .rejected       (rejected),
        .error_count    (error_count),
        .pending        (pending),
        .results_checked(results_checked),
        .refused_seen   (refused_seen),
        .full_seen      (full_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one operation; returns in the step of the accepting edge.
    task automatic offer_op(input deq_pkg::op_t op,
                            input logic signed [deq_pkg::DATA_W-1:0] val);
        if (!steady)
            while ($urandom_range(99) < 38)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= val;
        do @(posedge clk); while (!in_ready);
        ops_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Receiver: random back-pressure plus one long hold-off
    initial
    begin
        bit held_off;
        held_off = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_off && results_checked >= HOLD_OFF_AFTER)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 38);
        end
    end

    // Watchdog on cycles with no transaction on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int                                bias;
        int                                directed_ops;
        deq_pkg::op_t                      op;
        logic signed [deq_pkg::DATA_W-1:0] v;

        steady    = 1'b0;
        ops_sent  = 0;
        bias      = 50;
        in_valid  <= 1'b0;
        operation <= deq_pkg::OP_PUSH_FRONT;
        value     <= '0;
        rst_n     <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pops on an empty queue are refused
        offer_op(deq_pkg::OP_POP_FRONT, $urandom);
        offer_op(deq_pkg::OP_POP_BACK, $urandom);
        // fill from both ends, extremes first
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i)
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7fff_ffff;
                2:       v = '0;
                3:       v = -32'sd1;
                default: v = $urandom;
            endcase
            offer_op(i % 2 ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT, v);
        end
        // pushes on a full queue are dropped
        offer_op(deq_pkg::OP_PUSH_FRONT, $urandom);
        offer_op(deq_pkg::OP_PUSH_BACK, $urandom);
        offer_op(deq_pkg::OP_POP_FRONT, $urandom);
        offer_op(deq_pkg::OP_POP_BACK, $urandom);
        directed_ops = ops_sent;

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 32 == 0)
                case ($urandom_range(2))
                    0:       bias = 15;
                    1:       bias = 50;
                    default: bias = 85;
                endcase
            if (i == 500)
            begin
                wait_drained();
                steady = 1'b1;
            end
            if (i == 700) steady = 1'b0;

            if ($urandom_range(99) < bias)
                op = $urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
            else
                op = $urandom_range(1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
            case ($urandom_range(7))
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7fff_ffff;
                2:       v = '0;
                default: v = $urandom;
            endcase
            offer_op(op, v);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d deque operations (%0d directed), %0d results checked.",
                 ops_sent, directed_ops, results_checked);
        $display("%0d operations refused on a full or empty queue, %0d results at full depth.",
                 refused_seen, full_seen);
        if (error_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
